/* rtl/lhc_pkg.sv */
// Package with shared types, constants and command codes for the handle cache.
`default_nettype none
package lhc_pkg;
  localparam int Capacity = 16;
  localparam int SlotBits = 4;
  localparam int CountBits = 5;

  localparam logic [1:0] CmdLookup = 2'd0;
  localparam logic [1:0] CmdValidate = 2'd1;
  localparam logic [1:0] CmdInsert = 2'd2;
  localparam logic [1:0] CmdClear = 2'd3;

  localparam logic CfgTtl = 1'b0;
  localparam logic CfgLimit = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] key;
    logic [31:0] now_time;
    logic [31:0] mod_time;
    logic [15:0] handle;
    logic [39:0] length;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic        hit;
    logic [15:0] out_handle;
    logic [39:0] out_length;
    logic [31:0] out_mod_time;
    logic [4:0]  entries_in_use;
    logic        last;
  } out_item_t;

  // Contents of one slot.
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] handle;
    logic [39:0] length;
    logic [31:0] mod_time;
    logic [31:0] stamp;
  } entry_t;

  // Operation broadcast to every slot together.
  typedef struct packed {
    logic        promote;   // ranks below ref_rank step up by one
    logic        drop;      // ranks above ref_rank step down by one
    logic        age_all;   // every valid rank steps up (insert)
    logic [3:0]  ref_rank;
  } rank_op_t;
endpackage
`default_nettype wire

/* rtl/lhc_slot.sv */
// One cache slot: stored entry, valid bit, recency rank and local match logic.
`default_nettype none
module lhc_slot (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lhc_pkg::rank_op_t   op,
  input  wire logic                self_clear,
  input  wire logic                self_write,
  input  wire logic                self_restamp,
  input  wire logic                self_top,
  input  wire lhc_pkg::entry_t     wr_entry,
  input  wire logic [31:0]         key,
  output logic                     valid,
  output lhc_pkg::entry_t          entry,
  output logic [3:0]               rank,
  output logic                     match
);
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (self_clear) begin
      valid <= 1'b0;
    end else if (self_write) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (self_write) begin
      entry <= wr_entry;
      rank <= '0;
    end else begin
      if (self_restamp) begin
        entry.stamp <= wr_entry.stamp;
      end
      if (self_top) begin
        rank <= '0;
      end else if (valid && op.promote && rank < op.ref_rank) begin
        rank <= rank + 4'd1;
      end else if (valid && op.drop && rank > op.ref_rank) begin
        rank <= rank - 4'd1;
      end else if (valid && op.age_all) begin
        rank <= rank + 4'd1;
      end
    end
  end

  assign match = valid && (entry.key == key);
endmodule
`default_nettype wire

/* rtl/lru_handle_cache_with_ttl.sv */
// Top level of the LRU handle cache with TTL expiry.
// Items enter on in_valid/in_ready and results leave on out_valid/out_ready.
// Each item gives one or more results; only the final one has last set, and
// close notices (kind 1) for dropped handles come before it.
// The block works on one item at a time: a lookup or validate passes through
// the match register, the recency update and the output register. An insert
// also evicts the oldest entries while the cache is at its limit and then
// places the new entry; a clear drops each valid slot in turn. Sixteen slots
// sit in a row, each comparing its key and adjusting its own rank on a broadcast operation.
// Reset empties the cache, sets ttl_ticks to 5 and entry_limit to 16.
// Results are held in an output register; when the receiver stalls the block
// waits and loses nothing. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it while the block is idle (not enforced).
`default_nettype none
module lru_handle_cache_with_ttl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lhc_pkg::in_item_t    in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lhc_pkg::out_item_t        out_item,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [31:0]          cfg_data
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMatch = 3'd1;
  localparam logic [2:0] StAct = 3'd2;
  localparam logic [2:0] StEvict = 3'd3;
  localparam logic [2:0] StPlace = 3'd4;
  localparam logic [2:0] StClear = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;

  logic [31:0] ttl_ticks;
  logic [4:0]  entry_limit;
  logic [2:0]  state;
  lhc_pkg::in_item_t cur;
  logic [4:0]  used;
  logic        final_pending;
  logic        final_hit;
  logic [15:0] final_handle;
  logic [39:0] final_length;
  logic [31:0] final_mod_time;

  logic [lhc_pkg::Capacity-1:0] valid_v, match_v, clr_v, wr_v, rs_v, top_v;
  lhc_pkg::entry_t entry_a [lhc_pkg::Capacity];
  logic [3:0] rank_a [lhc_pkg::Capacity];
  lhc_pkg::rank_op_t op;
  lhc_pkg::entry_t wr_entry;

  // Registered match result.
  logic        m_found;
  logic [3:0]  m_slot;
  logic [3:0]  victim_slot, free_slot, first_valid;
  logic        victim_found, free_found, any_valid;
  logic [4:0]  lim;

  genvar g;
  generate
    for (g = 0; g < lhc_pkg::Capacity; g++) begin : g_slot
      lhc_slot u_slot (
        .clk(clk), .rst(rst), .op(op), .self_clear(clr_v[g]), .self_write(wr_v[g]),
        .self_restamp(rs_v[g]), .self_top(top_v[g]), .wr_entry(wr_entry),
        .key(cur.key), .valid(valid_v[g]), .entry(entry_a[g]), .rank(rank_a[g]),
        .match(match_v[g])
      );
    end
  endgenerate

  always_comb begin
    victim_found = 1'b0;
    victim_slot = '0;
    free_found = 1'b0;
    free_slot = '0;
    any_valid = 1'b0;
    first_valid = '0;
    for (int i = lhc_pkg::Capacity - 1; i >= 0; i--) begin
      if (!valid_v[i]) begin
        free_found = 1'b1;
        free_slot = 4'(i);
      end else begin
        any_valid = 1'b1;
        first_valid = 4'(i);
      end
      if (valid_v[i] && {1'b0, rank_a[i]} == used - 5'd1) begin
        victim_found = 1'b1;
        victim_slot = 4'(i);
      end
    end
  end

  always_comb begin
    if (entry_limit == 5'd0) begin
      lim = 5'd1;
    end else if (entry_limit > 5'(lhc_pkg::Capacity)) begin
      lim = 5'(lhc_pkg::Capacity);
    end else begin
      lim = entry_limit;
    end
  end

  logic [3:0] m_slot_c;
  logic       m_found_c;
  always_comb begin
    m_found_c = 1'b0;
    m_slot_c = '0;
    for (int i = lhc_pkg::Capacity - 1; i >= 0; i--) begin
      if (match_v[i]) begin
        m_found_c = 1'b1;
        m_slot_c = 4'(i);
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == StIdle);

  lhc_pkg::entry_t me;
  logic [31:0] age;
  assign me = entry_a[m_slot];
  assign age = cur.now_time - me.stamp;

  // Slot controls and the next result are decided together.
  logic        emit;
  lhc_pkg::out_item_t emit_item;
  logic [2:0]  state_next;
  logic [4:0]  used_next;
  logic        fp_next;

  always_comb begin
    op = '0;
    clr_v = '0;
    wr_v = '0;
    rs_v = '0;
    top_v = '0;
    wr_entry.key = cur.key;
    wr_entry.handle = cur.handle;
    wr_entry.length = cur.length;
    wr_entry.mod_time = cur.mod_time;
    wr_entry.stamp = cur.now_time;
    emit = 1'b0;
    emit_item = '0;
    state_next = state;
    used_next = used;
    fp_next = final_pending;
    case (state)
      StIdle: begin
        if (in_valid) begin
          state_next = StMatch;
        end
      end
      StMatch: begin
        state_next = StAct;
      end
      StAct: begin
        // One drop notice is the only thing that may need the output here.
        if (out_free) begin
          state_next = StEmit;
          fp_next = 1'b1;
          case (cur.cmd)
            lhc_pkg::CmdLookup: begin
              if (m_found && age < ttl_ticks) begin
                op.promote = 1'b1;
                op.ref_rank = rank_a[m_slot];
                top_v[m_slot] = 1'b1;
              end
            end
            lhc_pkg::CmdValidate: begin
              if (m_found && me.mod_time != cur.mod_time) begin
                op.drop = 1'b1;
                op.ref_rank = rank_a[m_slot];
                clr_v[m_slot] = 1'b1;
                used_next = used - 5'd1;
                emit = 1'b1;
                emit_item.kind = 1'b1;
                emit_item.out_handle = me.handle;
                emit_item.entries_in_use = used - 5'd1;
              end else if (m_found) begin
                op.promote = 1'b1;
                op.ref_rank = rank_a[m_slot];
                top_v[m_slot] = 1'b1;
                rs_v[m_slot] = 1'b1;
              end
            end
            lhc_pkg::CmdInsert: begin
              state_next = StEvict;
              fp_next = 1'b0;
              if (m_found) begin
                op.drop = 1'b1;
                op.ref_rank = rank_a[m_slot];
                clr_v[m_slot] = 1'b1;
                used_next = used - 5'd1;
                emit = 1'b1;
                emit_item.kind = 1'b1;
                emit_item.out_handle = me.handle;
                emit_item.entries_in_use = used - 5'd1;
              end
            end
            default: begin
              state_next = StClear;
              fp_next = 1'b0;
            end
          endcase
        end
      end
      StEvict: begin
        if (out_free) begin
          if (used >= lim && victim_found) begin
            op.drop = 1'b1;
            op.ref_rank = rank_a[victim_slot];
            clr_v[victim_slot] = 1'b1;
            used_next = used - 5'd1;
            emit = 1'b1;
            emit_item.kind = 1'b1;
            emit_item.out_handle = entry_a[victim_slot].handle;
            emit_item.entries_in_use = used - 5'd1;
          end else begin
            state_next = StPlace;
          end
        end
      end
      StPlace: begin
        if (free_found) begin
          op.age_all = 1'b1;
          wr_v[free_slot] = 1'b1;
          used_next = used + 5'd1;
        end
        fp_next = 1'b1;
        state_next = StEmit;
      end
      StClear: begin
        if (out_free) begin
          if (any_valid) begin
            clr_v[first_valid] = 1'b1;
            used_next = used - 5'd1;
            emit = 1'b1;
            emit_item.kind = 1'b1;
            emit_item.out_handle = entry_a[first_valid].handle;
            emit_item.entries_in_use = used - 5'd1;
          end else begin
            used_next = '0;
            fp_next = 1'b1;
            state_next = StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free && !emit) begin
          emit = 1'b1;
          emit_item.kind = 1'b0;
          emit_item.hit = final_hit;
          emit_item.out_handle = final_handle;
          emit_item.out_length = final_length;
          emit_item.out_mod_time = final_mod_time;
          emit_item.entries_in_use = used;
          emit_item.last = 1'b1;
          fp_next = 1'b0;
          state_next = StIdle;
        end
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl_ticks <= 32'd5;
      entry_limit <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == lhc_pkg::CfgTtl) begin
        ttl_ticks <= cfg_data;
      end else begin
        entry_limit <= cfg_data[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      used <= '0;
      out_valid <= 1'b0;
      final_pending <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      final_pending <= fp_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
    if (state == StIdle && in_valid) begin
      cur <= in_item;
    end
    if (state == StMatch) begin
      m_found <= m_found_c;
      m_slot <= m_slot_c;
    end
    if (state == StAct && out_free) begin
      final_hit <= 1'b0;
      final_handle <= '0;
      final_length <= '0;
      final_mod_time <= '0;
      if (cur.cmd == lhc_pkg::CmdLookup && m_found && age < ttl_ticks) begin
        final_hit <= 1'b1;
        final_handle <= me.handle;
        final_length <= me.length;
        final_mod_time <= me.mod_time;
      end else if (cur.cmd == lhc_pkg::CmdValidate && m_found &&
                   me.mod_time == cur.mod_time) begin
        final_hit <= 1'b1;
        final_handle <= me.handle;
      end
    end
  end
endmodule
`default_nettype wire
